### sv/rdc_pkg.sv
// Shared constants, control-word types and helpers for the radix digit converter.
package rdc_pkg;

    localparam int VALUE_BITS = 31;
    localparam int MAX_DIGITS = 32;

    localparam int RDX_W   = 6;
    localparam int DIG_W   = 6;
    localparam int CHAR_W  = 7;
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W   = $clog2(MAX_DIGITS);
    localparam int BIT_W   = $clog2(VALUE_BITS);
    localparam int STEP_W  = 4;

    localparam int S_DATA_W = ((VALUE_BITS + RDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((CHAR_W + 7) / 8) * 8;

    localparam logic [RDX_W-1:0]  RADIX_MIN        = RDX_W'(2);
    localparam logic [RDX_W-1:0]  RADIX_MAX        = RDX_W'(36);
    localparam logic [CHAR_W-1:0] ASCII_NUM_BASE   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_ALPHA_BASE = CHAR_W'(55);

    typedef logic [STEP_W-1:0] step_t;

    // microprogram addresses
    localparam step_t STEP_IDLE      = STEP_W'(0);
    localparam step_t STEP_CHECK     = STEP_W'(1);
    localparam step_t STEP_DIV_INIT  = STEP_W'(2);
    localparam step_t STEP_DIV_BIT   = STEP_W'(3);
    localparam step_t STEP_STORE     = STEP_W'(4);
    localparam step_t STEP_EMIT_INIT = STEP_W'(5);
    localparam step_t STEP_EMIT_WAIT = STEP_W'(6);
    localparam step_t STEP_PUSH      = STEP_W'(7);
    localparam step_t STEP_NEXT      = STEP_W'(8);
    localparam step_t STEP_EMPTY     = STEP_W'(9);

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_DIV_INIT,
        ACT_DIV_BIT,
        ACT_STORE,
        ACT_EMIT_INIT,
        ACT_PUSH,
        ACT_PUSH_EMPTY
    } act_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_IN_VALID,
        COND_BAD_RADIX,
        COND_BIT_LAST,
        COND_MORE_DIGITS,
        COND_OUT_FREE,
        COND_DONE
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t jmp;
        step_t nxt;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic bad_radix;
        logic bit_last;
        logic more_digits;
        logic out_free;
        logic done;
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d <= DIG_W'(9)) begin
            return ASCII_NUM_BASE + dx;
        end
        return ASCII_ALPHA_BASE + dx;
    endfunction

endpackage

### sv/radix_digit_converter_unit.sv
// Top level of the radix digit converter: datapath, digit store and output register.
//
// Each input item holds a value and a base. For a base of 2 to 36 the value is split into
// digits by repeated division, and one output item per digit is sent, most significant
// first, as an ASCII character ('0'-'9', 'A'-'Z'); the last carries tlast. Zero gives a
// single '0'. Any other base gives one item with tuser set, character 0 and tlast set.
// One item is handled at a time; s_tready is high only while the block waits for work.
// Steps: the block accepts the item and checks the base; per digit, the shared
// one-bit-per-cycle restoring divider runs over all 31 value bits and the remainder is
// stored; emission then starts, and per digit the digit store is read and the output
// register loaded, waiting while the sink is not ready. An invalid base goes straight to
// the single empty item.
module radix_digit_converter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rdc_pkg::S_DATA_W-1:0]  s_tdata,   // value[30:0], radix[36:31], zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rdc_pkg::M_DATA_W-1:0]  m_tdata,   // digit_char[6:0], zero fill
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser    // empty_result[0]
);

    rdc_pkg::act_t    act;
    rdc_pkg::status_t status;

    logic [rdc_pkg::VALUE_BITS-1:0] num_reg;
    logic [rdc_pkg::RDX_W-1:0]      radix_reg;
    logic [rdc_pkg::DIG_W-1:0]      rem_reg;
    logic [rdc_pkg::BIT_W-1:0]      bit_reg;
    logic [rdc_pkg::CNT_W-1:0]      n_reg;
    logic [rdc_pkg::CNT_W-1:0]      n_inc;
    logic [rdc_pkg::IDX_W-1:0]      idx_reg;
    logic                           done_reg;
    logic [rdc_pkg::DIG_W-1:0]      rd_reg;
    logic [rdc_pkg::DIG_W-1:0]      digit_mem [rdc_pkg::MAX_DIGITS];

    logic [rdc_pkg::DIG_W:0]        trial;
    logic                           q_bit;
    logic [rdc_pkg::DIG_W-1:0]      rem_next;
    logic [rdc_pkg::RDX_W-1:0]      in_radix;

    logic                           m_valid_reg;
    logic [rdc_pkg::CHAR_W-1:0]     m_char_reg;
    logic                           m_last_reg;
    logic                           m_empty_reg;
    logic                           out_free;
    logic                           load_digit;
    logic                           load_empty;

    rdc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .act     (act)
    );

    assign in_radix = s_tdata[rdc_pkg::VALUE_BITS +: rdc_pkg::RDX_W];
    assign s_tready = (act == rdc_pkg::ACT_ACCEPT);
    assign out_free = !m_valid_reg || m_tready;
    assign n_inc    = n_reg + rdc_pkg::CNT_W'(1);

    assign load_digit = (act == rdc_pkg::ACT_PUSH) && out_free;
    assign load_empty = (act == rdc_pkg::ACT_PUSH_EMPTY) && out_free;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, num_reg[rdc_pkg::VALUE_BITS-1]};
        q_bit    = (trial >= {1'b0, radix_reg});
        rem_next = q_bit ? rdc_pkg::DIG_W'(trial - {1'b0, radix_reg})
                         : rdc_pkg::DIG_W'(trial);
    end

    always_comb begin
        status.in_valid    = s_tvalid;
        status.bad_radix   = (radix_reg < rdc_pkg::RADIX_MIN) || (radix_reg > rdc_pkg::RADIX_MAX);
        status.bit_last    = (bit_reg == '0);
        status.more_digits = (num_reg != '0) && (n_inc < rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS));
        status.out_free    = out_free;
        status.done        = done_reg;
    end

    always_ff @(posedge aclk) begin
        case (act)
            rdc_pkg::ACT_ACCEPT: begin
                num_reg   <= s_tdata[rdc_pkg::VALUE_BITS-1:0];
                radix_reg <= in_radix;
                n_reg     <= '0;
            end
            rdc_pkg::ACT_DIV_INIT: begin
                rem_reg <= '0;
                bit_reg <= rdc_pkg::BIT_W'(rdc_pkg::VALUE_BITS - 1);
            end
            rdc_pkg::ACT_DIV_BIT: begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[rdc_pkg::VALUE_BITS-2:0], q_bit};
                bit_reg <= bit_reg - rdc_pkg::BIT_W'(1);
            end
            rdc_pkg::ACT_STORE: begin
                n_reg <= n_inc;
            end
            rdc_pkg::ACT_EMIT_INIT: begin
                idx_reg  <= rdc_pkg::IDX_W'(n_reg - rdc_pkg::CNT_W'(1));
                done_reg <= 1'b0;
            end
            rdc_pkg::ACT_PUSH: begin
                if (out_free) begin
                    idx_reg  <= idx_reg - rdc_pkg::IDX_W'(1);
                    done_reg <= (idx_reg == '0);
                end
            end
            default: begin
            end
        endcase
    end

    // digit store, least significant digit at entry 0
    always_ff @(posedge aclk) begin
        if (act == rdc_pkg::ACT_STORE) begin
            digit_mem[n_reg[rdc_pkg::IDX_W-1:0]] <= rem_reg;
        end
        rd_reg <= digit_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_digit || load_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_digit) begin
            m_char_reg  <= rdc_pkg::digit_to_ascii(rd_reg);
            m_last_reg  <= (idx_reg == '0);
            m_empty_reg <= 1'b0;
        end else if (load_empty) begin
            m_char_reg  <= '0;
            m_last_reg  <= 1'b1;
            m_empty_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = rdc_pkg::M_DATA_W'(m_char_reg);
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_empty_reg;

endmodule

### sv/rdc_sequencer.sv
// Microcode ROM and step counter of the radix digit converter.
module rdc_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  rdc_pkg::status_t    status,
    output rdc_pkg::act_t       act
);

    rdc_pkg::step_t      upc_reg;
    rdc_pkg::step_t      upc_next;
    rdc_pkg::ctrl_word_t word;
    logic                hit;

    function automatic rdc_pkg::ctrl_word_t rom(input rdc_pkg::step_t a);
        rdc_pkg::ctrl_word_t w;
        w = '{rdc_pkg::ACT_NONE, rdc_pkg::COND_NEVER, rdc_pkg::STEP_IDLE, rdc_pkg::STEP_IDLE};
        case (a)
            rdc_pkg::STEP_IDLE:      w = '{rdc_pkg::ACT_ACCEPT,     rdc_pkg::COND_IN_VALID,
                                           rdc_pkg::STEP_CHECK,     rdc_pkg::STEP_IDLE};
            rdc_pkg::STEP_CHECK:     w = '{rdc_pkg::ACT_NONE,       rdc_pkg::COND_BAD_RADIX,
                                           rdc_pkg::STEP_EMPTY,     rdc_pkg::STEP_DIV_INIT};
            rdc_pkg::STEP_DIV_INIT:  w = '{rdc_pkg::ACT_DIV_INIT,   rdc_pkg::COND_NEVER,
                                           rdc_pkg::STEP_DIV_BIT,   rdc_pkg::STEP_DIV_BIT};
            rdc_pkg::STEP_DIV_BIT:   w = '{rdc_pkg::ACT_DIV_BIT,    rdc_pkg::COND_BIT_LAST,
                                           rdc_pkg::STEP_STORE,     rdc_pkg::STEP_DIV_BIT};
            rdc_pkg::STEP_STORE:     w = '{rdc_pkg::ACT_STORE,      rdc_pkg::COND_MORE_DIGITS,
                                           rdc_pkg::STEP_DIV_INIT,  rdc_pkg::STEP_EMIT_INIT};
            rdc_pkg::STEP_EMIT_INIT: w = '{rdc_pkg::ACT_EMIT_INIT,  rdc_pkg::COND_NEVER,
                                           rdc_pkg::STEP_EMIT_WAIT, rdc_pkg::STEP_EMIT_WAIT};
            rdc_pkg::STEP_EMIT_WAIT: w = '{rdc_pkg::ACT_NONE,       rdc_pkg::COND_NEVER,
                                           rdc_pkg::STEP_PUSH,      rdc_pkg::STEP_PUSH};
            rdc_pkg::STEP_PUSH:      w = '{rdc_pkg::ACT_PUSH,       rdc_pkg::COND_OUT_FREE,
                                           rdc_pkg::STEP_NEXT,      rdc_pkg::STEP_PUSH};
            rdc_pkg::STEP_NEXT:      w = '{rdc_pkg::ACT_NONE,       rdc_pkg::COND_DONE,
                                           rdc_pkg::STEP_IDLE,      rdc_pkg::STEP_EMIT_WAIT};
            rdc_pkg::STEP_EMPTY:     w = '{rdc_pkg::ACT_PUSH_EMPTY, rdc_pkg::COND_OUT_FREE,
                                           rdc_pkg::STEP_IDLE,      rdc_pkg::STEP_EMPTY};
            default:                 w = '{rdc_pkg::ACT_NONE,       rdc_pkg::COND_NEVER,
                                           rdc_pkg::STEP_IDLE,      rdc_pkg::STEP_IDLE};
        endcase
        return w;
    endfunction

    always_comb begin
        word = rom(upc_reg);
        case (word.cond)
            rdc_pkg::COND_NEVER:       hit = 1'b0;
            rdc_pkg::COND_IN_VALID:    hit = status.in_valid;
            rdc_pkg::COND_BAD_RADIX:   hit = status.bad_radix;
            rdc_pkg::COND_BIT_LAST:    hit = status.bit_last;
            rdc_pkg::COND_MORE_DIGITS: hit = status.more_digits;
            rdc_pkg::COND_OUT_FREE:    hit = status.out_free;
            rdc_pkg::COND_DONE:        hit = status.done;
            default:                   hit = 1'b0;
        endcase
        upc_next = hit ? word.jmp : word.nxt;
        act      = word.act;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= rdc_pkg::STEP_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

### tb/radix_digit_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the radix digit converter: predicts each digit item and checks the output stream.
module radix_digit_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rdc_pkg::S_DATA_W-1:0]  s_tdata,    // value[30:0], radix[36:31], zero fill
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rdc_pkg::M_DATA_W-1:0]  m_tdata,    // digit_char[6:0], zero fill
    input  logic                          m_tlast,
    input  logic [0:0]                    m_tuser,    // empty_result[0]
    output int unsigned                   fail_count,
    output int unsigned                   pending_count
);

    typedef struct packed {
        logic [rdc_pkg::CHAR_W-1:0] digit_char;
        logic                       is_last;
        logic                       empty_result;
    } digit_item_t;

    digit_item_t               expected_digits[$];
    logic [rdc_pkg::DIG_W-1:0] remainder_store [rdc_pkg::MAX_DIGITS];
    int unsigned               result_index;
    digit_item_t               got_item;
    digit_item_t               want_item;

    // Splits one input item into the digit items the block has to send for it.
    task automatic predict_digits(input logic [rdc_pkg::VALUE_BITS-1:0] value,
                                  input logic [rdc_pkg::RDX_W-1:0] radix);
        logic [rdc_pkg::VALUE_BITS-1:0] rest;
        logic [rdc_pkg::DIG_W-1:0]      d;
        int                             n;
        digit_item_t                    item;
        if (radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX) begin
            item.digit_char   = '0;
            item.is_last      = 1'b1;
            item.empty_result = 1'b1;
            expected_digits.push_back(item);
        end else begin
            rest = value;
            n    = 0;
            // remainders land least significant first
            do begin
                remainder_store[n] = rdc_pkg::DIG_W'(rest % radix);
                rest = rest / radix;
                n++;
            end while (rest != 0 && n < rdc_pkg::MAX_DIGITS);
            for (int k = n - 1; k >= 0; k--) begin
                d = remainder_store[k];
                if (d <= 9) begin
                    item.digit_char = rdc_pkg::ASCII_NUM_BASE + rdc_pkg::CHAR_W'(d);
                end else begin
                    item.digit_char = rdc_pkg::ASCII_ALPHA_BASE + rdc_pkg::CHAR_W'(d);
                end
                item.is_last      = (k == 0);
                item.empty_result = 1'b0;
                expected_digits.push_back(item);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_digits.delete();
        end else begin
            // drain first: a result can never belong to an item taken at the same edge
            if (m_tvalid && m_tready) begin
                got_item.digit_char   = m_tdata[rdc_pkg::CHAR_W-1:0];
                got_item.is_last      = m_tlast;
                got_item.empty_result = m_tuser[0];
                if (expected_digits.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("result %0d: unexpected item char %0d last %0b empty %0b",
                                 result_index, got_item.digit_char, got_item.is_last,
                                 got_item.empty_result);
                    end
                    fail_count++;
                end else begin
                    want_item = expected_digits.pop_front();
                    if (got_item !== want_item) begin
                        if (fail_count < 10) begin
                            $display({"result %0d: char exp %0d got %0d, last exp %0b got %0b,",
                                      " empty exp %0b got %0b"},
                                     result_index, want_item.digit_char, got_item.digit_char,
                                     want_item.is_last, got_item.is_last,
                                     want_item.empty_result, got_item.empty_result);
                        end
                        fail_count++;
                    end
                end
                result_index++;
            end
            if (s_tvalid && s_tready) begin
                predict_digits(s_tdata[rdc_pkg::VALUE_BITS-1:0],
                               s_tdata[rdc_pkg::VALUE_BITS +: rdc_pkg::RDX_W]);
            end
        end
        pending_count = expected_digits.size();
    end

endmodule

### tb/tb_radix_digit_converter_unit.sv
`timescale 1ns / 1ps
// Top of the radix digit converter testbench: clock, reset, stimulus, sink and verdict.
module tb_radix_digit_converter_unit;

    localparam int N_RANDOM        = 310;
    localparam int RESET_CYCLES    = 6;
    localparam int HOLD_START      = 3000;
    localparam int HOLD_CYCLES     = 2500;
    localparam int STEADY_RX_FIRST = 8000;
    localparam int STEADY_RX_LAST  = 20000;
    localparam int DRAIN_CYCLES    = 1200;
    localparam logic [rdc_pkg::VALUE_BITS-1:0] VALUE_MAX = '1;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [rdc_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [rdc_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tlast;
    logic [0:0]                   m_tuser;
    int unsigned                  fail_count;
    int unsigned                  pending_count;
    bit                           steady_tx = 1'b0;

    always #2 aclk = ~aclk;

    radix_digit_converter_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    radix_digit_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    task automatic send_item(input logic [rdc_pkg::VALUE_BITS-1:0] value,
                             input logic [rdc_pkg::RDX_W-1:0] radix);
        while (!steady_tx && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rdc_pkg::S_DATA_W'({radix, value});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [rdc_pkg::VALUE_BITS-1:0] pick_value(
        input logic [rdc_pkg::RDX_W-1:0] radix);
        longint pw;
        int     k;
        int     sel;
        sel = $urandom_range(0, 99);
        if (sel < 40 || radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX) begin
            return rdc_pkg::VALUE_BITS'($urandom);
        end
        if (sel < 60) begin
            return rdc_pkg::VALUE_BITS'($urandom_range(0, 1000));
        end
        if (sel < 75) begin
            return rdc_pkg::VALUE_BITS'($urandom) >> $urandom_range(0, rdc_pkg::VALUE_BITS - 1);
        end
        if (sel < 85) begin
            return VALUE_MAX - rdc_pkg::VALUE_BITS'($urandom_range(0, 3));
        end
        // next to a power of the base, where the digit count steps up
        pw = 1;
        k  = $urandom_range(1, 31);
        for (int i = 0; i < k && pw * radix <= longint'(VALUE_MAX); i++) begin
            pw = pw * radix;
        end
        return rdc_pkg::VALUE_BITS'(pw - 1 + longint'($urandom_range(0, 2)));
    endfunction

    // sink: random stalls, one long hold-off to back the block up, then a steady stretch
    initial begin : sink
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
                m_tready <= 1'b0;
            end else if (cyc >= STEADY_RX_FIRST && cyc < STEADY_RX_LAST) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    initial begin : stimulus
        logic [rdc_pkg::RDX_W-1:0] radix;
        int                        r;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item('0, rdc_pkg::RADIX_MIN);
        send_item('0, rdc_pkg::RADIX_MAX);
        send_item(VALUE_MAX, rdc_pkg::RADIX_MIN);
        send_item(VALUE_MAX, rdc_pkg::RADIX_MAX);
        send_item(VALUE_MAX, 6'd10);
        send_item(VALUE_MAX, 6'd3);
        send_item(31'd1, rdc_pkg::RADIX_MIN);
        send_item(31'd35, rdc_pkg::RADIX_MAX);
        send_item(31'd36, rdc_pkg::RADIX_MAX);
        send_item(31'd9, 6'd10);
        send_item(31'd10, 6'd11);
        send_item(31'h0DEA_DBEE, 6'd16);
        send_item(31'd1295, rdc_pkg::RADIX_MAX);
        send_item(31'd1296, rdc_pkg::RADIX_MAX);
        send_item(31'h2AAA_AAAA, 6'd32);
        send_item(31'h1555_5555, 6'd4);
        // invalid bases
        send_item('0, 6'd0);
        send_item(VALUE_MAX, 6'd1);
        send_item(31'd12345, 6'd37);
        send_item(VALUE_MAX, 6'd63);

        for (int i = 0; i < N_RANDOM; i++) begin
            steady_tx = (i >= 150 && i < 200);
            if ($urandom_range(0, 9) == 0) begin
                r     = $urandom_range(0, 28);
                radix = rdc_pkg::RDX_W'((r < 2) ? r : r + 35);
            end else begin
                radix = rdc_pkg::RDX_W'($urandom_range(rdc_pkg::RADIX_MIN, rdc_pkg::RADIX_MAX));
            end
            send_item(pick_value(radix), radix);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_radix_digit_converter_unit: clean");
        end else begin
            $display("tb_radix_digit_converter_unit: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("tb_radix_digit_converter_unit: errors");
        $finish;
    end

endmodule
